// File: rtl/ftfm_pkg.sv
package ftfm_pkg;

  // Default width of the monitored sample and the reference.
  localparam int unsigned VALUE_WIDTH_DEF = 16;

  // Configuration register file: eight 32-bit registers at byte offsets 4*i.
  localparam int unsigned CFG_ADDR_W = 5;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned REG_IDX_W  = 3;

  localparam logic [REG_IDX_W-1:0] REG_CHECK_ENABLE  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_COMPARE_MODE  = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_SOURCE_MASK   = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_TRIP_THRESH   = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_CLEAR_THRESH  = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_TRIP_LIMIT    = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_RELEASE_LIMIT = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_FAULT_CLASS   = 3'd7;

  // Threshold and counter register width.
  localparam int unsigned LEVEL_W = 16;
  localparam logic [LEVEL_W-1:0] COUNT_MAX = '1;

  // compare_mode layout.
  localparam int unsigned MODE_W      = 4;
  localparam int unsigned MODE_DYN_BIT = 3;
  localparam int unsigned REL_W       = 3;

  localparam logic [REL_W-1:0] REL_ABOVE   = 3'd0;
  localparam logic [REL_W-1:0] REL_BELOW   = 3'd1;
  localparam logic [REL_W-1:0] REL_BOOL    = 3'd2;
  localparam logic [REL_W-1:0] REL_EQ      = 3'd3;
  localparam logic [REL_W-1:0] REL_NE      = 3'd4;
  localparam logic [REL_W-1:0] REL_OUTSIDE = 3'd5;
  localparam logic [REL_W-1:0] REL_INSIDE  = 3'd6;

  // fault_class bit positions.
  localparam int unsigned CLASS_W  = 5;
  localparam int unsigned CLS_CATA = 0;
  localparam int unsigned CLS_CRIT = 1;
  localparam int unsigned CLS_WARN = 2;
  localparam int unsigned CLS_NOTE = 3;
  localparam int unsigned CLS_USER = 4;

  // Result word, condition_active in bit 0 up to mode_error in bit 11.
  typedef struct packed {
    logic mode_error;
    logic restart_request;
    logic override_flag;
    logic global_notify_flag;
    logic global_warning_flag;
    logic global_fault_flag;
    logic user_release_pulse;
    logic user_trip_pulse;
    logic release_event;
    logic trip_event;
    logic fault_latched;
    logic condition_active;
  } result_t;

  localparam int unsigned RESULT_W = $bits(result_t);
  localparam int unsigned M_TDATA_W = ((RESULT_W + 7) / 8) * 8;

endpackage

// File: rtl/filtered_threshold_fault_monitor.sv
// Threshold fault monitor with hysteresis and a debounce counter. Each input word
// carries one sample (bits VALUE_WIDTH-1:0) and one reference (next VALUE_WIDTH bits);
// each accepted word yields exactly one result word of twelve status bits. The
// sample is masked, optionally replaced by |sample - reference|, compared against
// the programmed relation, and the raw condition drives a saturating 16-bit filter
// counter that trips and releases the latched fault and the global class flags.
// Throughput is one word per clock: the compare, the counter update and the flag
// update all settle in the single cycle that accepts the word, and the result sits
// in one output register that is refilled in the same cycle it is taken, so the
// input stalls only while that register is full and not taken. m_tvalid rises in
// the cycle after acceptance. Registers are written over the APB port only while
// no word is in flight: the user must keep to this, the block does not enforce it.
module filtered_threshold_fault_monitor
  import ftfm_pkg::*;
#(
  parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  // APB configuration port
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [CFG_ADDR_W-1:0]                  paddr,
  input  logic [CFG_DATA_W-1:0]                  pwdata,
  output logic [CFG_DATA_W-1:0]                  prdata,
  output logic                                   pready,
  // sample stream
  input  logic                                   s_tvalid,
  output logic                                   s_tready,
  // s_tdata, low bit up: sample_value, reference_value, zero pad
  input  logic [((2*VALUE_WIDTH+7)/8)*8-1:0]     s_tdata,
  // result stream
  output logic                                   m_tvalid,
  input  logic                                   m_tready,
  // m_tdata, low bit up: condition_active, fault_latched, trip_event, release_event,
  // user_trip_pulse, user_release_pulse, global_fault_flag, global_warning_flag,
  // global_notify_flag, override_flag, restart_request, mode_error, zero pad
  output logic [M_TDATA_W-1:0]                   m_tdata
);

  // Compare width: wide enough for both the sample and the 16-bit levels.
  localparam int unsigned CMP_W = (VALUE_WIDTH > LEVEL_W) ? VALUE_WIDTH : LEVEL_W;

  // configuration registers
  logic                 check_enable;
  logic [MODE_W-1:0]    compare_mode;
  logic [LEVEL_W-1:0]   source_mask;
  logic [LEVEL_W-1:0]   trip_thresh;
  logic [LEVEL_W-1:0]   clear_thresh;
  logic [LEVEL_W-1:0]   trip_count_limit;
  logic [LEVEL_W-1:0]   release_count_limit;
  logic [CLASS_W-1:0]   fault_class;

  // monitor state
  logic                 active_flag, active_flag_next;
  logic                 latched_flag, latched_flag_next;
  logic [LEVEL_W-1:0]   filter_count, filter_count_next;
  logic                 sys_fault, sys_fault_next;
  logic                 sys_warning, sys_warning_next;
  logic                 sys_notify, sys_notify_next;
  logic                 override_bit, override_bit_next;
  logic                 restart_bit, restart_bit_next;

  // output register
  logic                 out_valid;
  result_t              out_word;
  result_t              res;

  logic                 in_accept;
  logic                 cfg_write;
  logic [REG_IDX_W-1:0] reg_idx;

  logic [VALUE_WIDTH-1:0] sample_value;
  logic [VALUE_WIDTH-1:0] reference_value;
  logic [VALUE_WIDTH-1:0] masked;
  logic [VALUE_WIDTH-1:0] value;
  logic [CMP_W-1:0]       v;
  logic [CMP_W-1:0]       hi;
  logic [CMP_W-1:0]       lo;
  logic                   merr;
  logic [LEVEL_W-1:0]     count_inc;
  logic                   trip, rel;
  logic [CLASS_W-1:0]     code;

  assign pready    = 1'b1;
  assign reg_idx   = paddr[REG_IDX_W+1:2];
  assign cfg_write = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      check_enable        <= 1'b1;
      compare_mode        <= '0;
      source_mask         <= '1;
      trip_thresh         <= '0;
      clear_thresh        <= '0;
      trip_count_limit    <= '0;
      release_count_limit <= '0;
      fault_class         <= '0;
    end else if (cfg_write) begin
      case (reg_idx)
        REG_CHECK_ENABLE:  check_enable        <= pwdata[0];
        REG_COMPARE_MODE:  compare_mode        <= pwdata[MODE_W-1:0];
        REG_SOURCE_MASK:   source_mask         <= pwdata[LEVEL_W-1:0];
        REG_TRIP_THRESH:   trip_thresh         <= pwdata[LEVEL_W-1:0];
        REG_CLEAR_THRESH:  clear_thresh        <= pwdata[LEVEL_W-1:0];
        REG_TRIP_LIMIT:    trip_count_limit    <= pwdata[LEVEL_W-1:0];
        REG_RELEASE_LIMIT: release_count_limit <= pwdata[LEVEL_W-1:0];
        REG_FAULT_CLASS:   fault_class         <= pwdata[CLASS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_CHECK_ENABLE:  prdata = CFG_DATA_W'(check_enable);
      REG_COMPARE_MODE:  prdata = CFG_DATA_W'(compare_mode);
      REG_SOURCE_MASK:   prdata = CFG_DATA_W'(source_mask);
      REG_TRIP_THRESH:   prdata = CFG_DATA_W'(trip_thresh);
      REG_CLEAR_THRESH:  prdata = CFG_DATA_W'(clear_thresh);
      REG_TRIP_LIMIT:    prdata = CFG_DATA_W'(trip_count_limit);
      REG_RELEASE_LIMIT: prdata = CFG_DATA_W'(release_count_limit);
      REG_FAULT_CLASS:   prdata = CFG_DATA_W'(fault_class);
      default:           prdata = '0;
    endcase
  end

  // Refill the output register in the same cycle it is drained.
  assign s_tready  = ~out_valid | m_tready;
  assign in_accept = s_tvalid & s_tready;

  assign sample_value    = s_tdata[VALUE_WIDTH-1:0];
  assign reference_value = s_tdata[2*VALUE_WIDTH-1:VALUE_WIDTH];

  // mask, then optional absolute difference
  always_comb begin
    masked = sample_value & VALUE_WIDTH'({{CMP_W{1'b0}}, source_mask});
    if (compare_mode[MODE_DYN_BIT]) begin
      value = (masked >= reference_value) ? masked - reference_value
                                          : reference_value - masked;
    end else begin
      value = masked;
    end
    v  = CMP_W'(value);
    hi = CMP_W'(trip_thresh);
    lo = CMP_W'(clear_thresh);
  end

  // relation
  always_comb begin
    active_flag_next = active_flag;
    merr             = 1'b0;
    case (compare_mode[REL_W-1:0])
      REL_ABOVE: begin
        if (v > hi) active_flag_next = 1'b1;
        else if (v < lo) active_flag_next = 1'b0;
      end
      REL_BELOW: begin
        if (v < hi) active_flag_next = 1'b1;
        else if (v > lo) active_flag_next = 1'b0;
      end
      REL_BOOL:    active_flag_next = ((v != '0) == (hi != '0));
      REL_EQ:      active_flag_next = (v == hi);
      REL_NE:      active_flag_next = (v != hi);
      REL_OUTSIDE: active_flag_next = (v > hi) || (v < lo);
      REL_INSIDE:  active_flag_next = (lo < v) && (v < hi);
      default:     merr = 1'b1;
    endcase
    if (!check_enable) begin
      active_flag_next = active_flag;
      merr             = 1'b0;
    end
  end

  // debounce filter and class flags
  always_comb begin
    count_inc         = (filter_count == COUNT_MAX) ? filter_count
                                                    : filter_count + LEVEL_W'(1);
    filter_count_next = filter_count;
    latched_flag_next = latched_flag;
    trip              = 1'b0;
    rel               = 1'b0;
    code              = '0;
    if (check_enable) begin
      if (!latched_flag) begin
        if (active_flag_next) begin
          filter_count_next = count_inc;
          if (count_inc >= trip_count_limit) begin
            latched_flag_next = 1'b1;
            trip              = 1'b1;
          end
        end else begin
          filter_count_next = '0;
        end
      end else begin
        if (!active_flag_next) begin
          filter_count_next = count_inc;
          if (count_inc >= release_count_limit) begin
            latched_flag_next = 1'b0;
            rel               = 1'b1;
          end
        end else begin
          filter_count_next = '0;
        end
      end
      if (latched_flag_next) code = fault_class;
    end

    // set on trip, then drop every flag whose class is not held; restart_request stays set
    sys_fault_next      = (sys_fault | (trip & (fault_class[CLS_CATA] |
                           fault_class[CLS_CRIT]))) & code[CLS_CRIT];
    override_bit_next   = (override_bit | (trip & (fault_class[CLS_CATA] |
                           fault_class[CLS_CRIT]))) & code[CLS_CRIT];
    sys_warning_next    = (sys_warning | (trip & ~fault_class[CLS_CATA] &
                           fault_class[CLS_WARN])) & code[CLS_WARN];
    sys_notify_next     = (sys_notify | (trip & ~fault_class[CLS_CATA] &
                           fault_class[CLS_NOTE])) & code[CLS_NOTE];
    restart_bit_next    = restart_bit | (trip & fault_class[CLS_CATA]);
  end

  always_comb begin
    res.condition_active    = active_flag_next;
    res.fault_latched       = latched_flag_next;
    res.trip_event          = trip;
    res.release_event       = rel;
    res.user_trip_pulse     = trip & fault_class[CLS_USER] & ~fault_class[CLS_CATA];
    res.user_release_pulse  = rel & fault_class[CLS_USER];
    res.global_fault_flag   = sys_fault_next;
    res.global_warning_flag = sys_warning_next;
    res.global_notify_flag  = sys_notify_next;
    res.override_flag       = override_bit_next;
    res.restart_request     = restart_bit_next;
    res.mode_error          = merr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active_flag    <= 1'b0;
      latched_flag   <= 1'b0;
      filter_count   <= '0;
      sys_fault      <= 1'b1;
      sys_warning    <= 1'b1;
      sys_notify     <= 1'b1;
      override_bit   <= 1'b0;
      restart_bit    <= 1'b0;
    end else if (in_accept) begin
      active_flag    <= active_flag_next;
      latched_flag   <= latched_flag_next;
      filter_count   <= filter_count_next;
      sys_fault      <= sys_fault_next;
      sys_warning    <= sys_warning_next;
      sys_notify     <= sys_notify_next;
      override_bit   <= override_bit_next;
      restart_bit    <= restart_bit_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_word <= res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = M_TDATA_W'(out_word);

endmodule

// File: dv/tb_filtered_threshold_fault_monitor.sv
`timescale 1ns / 100ps

module tb_filtered_threshold_fault_monitor;
  import ftfm_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned LONG_RUN    = 100;
  localparam logic [REL_W-1:0] REL_INVALID = 3'd7;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                  psel    = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite  = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr   = '0;
  logic [CFG_DATA_W-1:0] pwdata  = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  // s_tdata, low bit up: sample_value, reference_value
  logic [31:0]           s_tdata  = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b1;
  // m_tdata, low bit up: condition_active .. mode_error, zero pad
  logic [M_TDATA_W-1:0]  m_tdata;

  filtered_threshold_fault_monitor u_top (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #5 clk = ~clk;

  // Shadow of the register file
  logic                cfg_enable   = 1'b1;
  logic [MODE_W-1:0]   cfg_mode     = '0;
  logic [LEVEL_W-1:0]  cfg_mask     = '1;
  logic [LEVEL_W-1:0]  cfg_trip     = '0;
  logic [LEVEL_W-1:0]  cfg_reset    = '0;
  logic [LEVEL_W-1:0]  cfg_trip_lim = '0;
  logic [LEVEL_W-1:0]  cfg_rel_lim  = '0;
  logic [CLASS_W-1:0]  cfg_class    = '0;

  // Monitor state as the block should hold it
  logic               cond_q  = 1'b0;
  logic               latch_q = 1'b0;
  logic [LEVEL_W-1:0] fcount  = '0;
  logic               gflt    = 1'b1;
  logic               gwarn   = 1'b1;
  logic               gnote   = 1'b1;
  logic               ovr     = 1'b0;
  logic               restart = 1'b0;

  logic [31:0] sample_q [$];
  result_t     status_q [$];

  logic word_sent  = 1'b0;
  logic steady     = 1'b0;
  int   send_gap   = 0;
  int   take_gap   = 0;
  int   mismatches = 0;
  int   cycle_count = 0;

  string status_name [RESULT_W] = '{
    "condition_active", "fault_latched", "trip_event", "release_event",
    "user_trip_pulse", "user_release_pulse", "global_fault_flag",
    "global_warning_flag", "global_notify_flag", "override_flag",
    "restart_request", "mode_error"};

  function automatic result_t next_status(input logic [LEVEL_W-1:0] smp,
                                          input logic [LEVEL_W-1:0] refval);
    result_t            r;
    logic [LEVEL_W-1:0] v;
    logic [CLASS_W-1:0] code;
    r    = '0;
    code = '0;
    if (cfg_enable) begin
      v = smp & cfg_mask;
      if (cfg_mode[MODE_DYN_BIT]) v = (v >= refval) ? v - refval : refval - v;
      case (cfg_mode[REL_W-1:0])
        REL_ABOVE: begin
          if (v > cfg_trip) cond_q = 1'b1;
          else if (v < cfg_reset) cond_q = 1'b0;
        end
        REL_BELOW: begin
          if (v < cfg_trip) cond_q = 1'b1;
          else if (v > cfg_reset) cond_q = 1'b0;
        end
        REL_BOOL:    cond_q = ((v != 0) == (cfg_trip != 0));
        REL_EQ:      cond_q = (v == cfg_trip);
        REL_NE:      cond_q = (v != cfg_trip);
        REL_OUTSIDE: cond_q = (v > cfg_trip) || (v < cfg_reset);
        REL_INSIDE:  cond_q = (cfg_reset < v) && (v < cfg_trip);
        default:     r.mode_error = 1'b1;
      endcase
      if (!latch_q) begin
        if (cond_q) begin
          if (fcount != COUNT_MAX) fcount++;
          if (fcount >= cfg_trip_lim) begin
            latch_q = 1'b1;
            r.trip_event = 1'b1;
            if (cfg_class[CLS_CATA]) begin
              gflt = 1'b1; ovr = 1'b1; restart = 1'b1;
            end else begin
              if (cfg_class[CLS_CRIT]) begin
                gflt = 1'b1; ovr = 1'b1;
              end
              if (cfg_class[CLS_WARN]) gwarn = 1'b1;
              if (cfg_class[CLS_NOTE]) gnote = 1'b1;
              if (cfg_class[CLS_USER]) r.user_trip_pulse = 1'b1;
            end
          end
        end else begin
          fcount = '0;
        end
      end else begin
        if (!cond_q) begin
          if (fcount != COUNT_MAX) fcount++;
          if (fcount >= cfg_rel_lim) begin
            latch_q = 1'b0;
            r.release_event = 1'b1;
            if (cfg_class[CLS_USER]) r.user_release_pulse = 1'b1;
          end
        end else begin
          fcount = '0;
        end
      end
      if (latch_q) code = cfg_class;
    end
    // release step runs on every word
    if (!code[CLS_CRIT]) begin
      gflt = 1'b0; ovr = 1'b0;
    end
    if (!code[CLS_WARN]) gwarn = 1'b0;
    if (!code[CLS_NOTE]) gnote = 1'b0;
    r.condition_active    = cond_q;
    r.fault_latched       = latch_q;
    r.global_fault_flag   = gflt;
    r.global_warning_flag = gwarn;
    r.global_notify_flag  = gnote;
    r.override_flag       = ovr;
    r.restart_request     = restart;
    return r;
  endfunction

  // Sample driver: hold a word until taken, then wait a drawn gap
  always @(negedge clk) begin
    if (!rst && (!s_tvalid || word_sent)) begin
      if (send_gap > 0) begin
        send_gap--;
        s_tvalid <= 1'b0;
      end else if (sample_q.size() > 0) begin
        s_tdata  <= sample_q.pop_front();
        s_tvalid <= 1'b1;
        send_gap = steady ? 0 : $urandom_range(0, 3);
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (take_gap > 0) begin
      take_gap--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Result monitor and prediction on accepted words
  always @(posedge clk) begin : monitor
    result_t             want;
    logic [RESULT_W-1:0] want_bits;
    logic [RESULT_W-1:0] got;
    word_sent = s_tvalid && s_tready;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        got = m_tdata[RESULT_W-1:0];
        take_gap = steady ? 0 : $urandom_range(0, 3);
        if (status_q.size() == 0) begin
          if (mismatches < 50)
            $display("%0t: unexpected result word, expected none, got %h", $time, got);
          mismatches++;
        end else begin
          want = status_q.pop_front();
          want_bits = want;
          for (int i = 0; i < RESULT_W; i++) begin
            if (got[i] !== want_bits[i]) begin
              if (mismatches < 50)
                $display("%0t: %s expected %0b got %0b", $time, status_name[i],
                         want_bits[i], got[i]);
              mismatches++;
            end
          end
        end
      end
      if (word_sent) status_q.push_back(next_status(s_tdata[15:0], s_tdata[31:16]));
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_filtered_threshold_fault_monitor NOT OK");
      $finish;
    end
  end

  task automatic cfg_write(input logic [REG_IDX_W-1:0] idx, input logic [31:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_CHECK_ENABLE:  cfg_enable   = val[0];
      REG_COMPARE_MODE:  cfg_mode     = val[MODE_W-1:0];
      REG_SOURCE_MASK:   cfg_mask     = val[LEVEL_W-1:0];
      REG_TRIP_THRESH:   cfg_trip     = val[LEVEL_W-1:0];
      REG_CLEAR_THRESH:  cfg_reset    = val[LEVEL_W-1:0];
      REG_TRIP_LIMIT:    cfg_trip_lim = val[LEVEL_W-1:0];
      REG_RELEASE_LIMIT: cfg_rel_lim  = val[LEVEL_W-1:0];
      REG_FAULT_CLASS:   cfg_class    = val[CLASS_W-1:0];
      default: ;
    endcase
  endtask

  task automatic push_word(input logic [15:0] smp, input logic [15:0] refval);
    sample_q.push_back({refval, smp});
  endtask

  // Hold until every word is sent and every result has come back
  task automatic wait_idle();
    do @(posedge clk);
    while (sample_q.size() != 0 || s_tvalid || status_q.size() != 0);
    repeat (2) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_level();
    case ($urandom_range(0, 5))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'($urandom_range(0, 16));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_limit();
    case ($urandom_range(0, 9))
      0:       return 16'hFFFF;
      1:       return 16'($urandom);
      default: return 16'($urandom_range(0, 4));
    endcase
  endfunction

  function automatic logic [15:0] near(input logic [15:0] base);
    return base + 16'($urandom_range(0, 6)) - 16'd3;
  endfunction

  initial begin
    logic [REL_W-1:0] rel_list [8];
    logic [15:0]      smp;
    logic [15:0]      refval;
    rel_list = '{REL_ABOVE, REL_BELOW, REL_BOOL, REL_EQ, REL_NE, REL_OUTSIDE,
                 REL_INSIDE, REL_INVALID};
    repeat (6) @(negedge clk);
    rst <= 1'b0;

    // Reset settings: extremes of both fields
    push_word(16'h0000, 16'h0000);
    push_word(16'hFFFF, 16'hFFFF);
    push_word(16'h0000, 16'hFFFF);
    push_word(16'hFFFF, 16'h0000);
    wait_idle();

    // Every relation, alternately static and dynamic, invalid code last
    cfg_write(REG_TRIP_THRESH, 32'h0100);
    cfg_write(REG_CLEAR_THRESH, 32'h0080);
    cfg_write(REG_TRIP_LIMIT, 32'd1);
    cfg_write(REG_RELEASE_LIMIT, 32'd0);
    for (int i = 0; i < 8; i++) begin
      cfg_write(REG_COMPARE_MODE, {28'd0, 1'(i % 2), rel_list[i]});
      cfg_write(REG_FAULT_CLASS, 32'(5'(i * 9)));
      push_word(16'h0120, 16'h0010);
      push_word(16'h0050, 16'h0000);
      push_word(16'h0100, 16'h0100);
      wait_idle();
    end

    // Check disabled: condition and filter hold, only the release step runs
    cfg_write(REG_CHECK_ENABLE, 32'd0);
    push_word(16'hFFFF, 16'h0000);
    push_word(16'h0000, 16'h0000);
    wait_idle();
    cfg_write(REG_CHECK_ENABLE, 32'd1);

    // Long debounce run: trip exactly at the limit, then release on the first zero word
    cfg_write(REG_COMPARE_MODE, {28'd0, 1'b0, REL_NE});
    cfg_write(REG_TRIP_THRESH, 32'd0);
    cfg_write(REG_FAULT_CLASS, 32'd1 << CLS_USER);
    push_word(16'h0000, 16'h0000);
    push_word(16'h0000, 16'h0000);
    wait_idle();
    cfg_write(REG_TRIP_LIMIT, 32'(LONG_RUN));
    cfg_write(REG_RELEASE_LIMIT, 32'd1);
    steady = 1'b1;
    for (int i = 0; i < LONG_RUN; i++) push_word(16'h0001, 16'($urandom));
    push_word(16'h0000, 16'h0000);
    push_word(16'h0000, 16'h0000);
    wait_idle();

    // Random settings and words clustered around the programmed levels
    for (int ph = 0; ph < 24; ph++) begin
      steady = ($urandom_range(0, 3) == 0);
      cfg_write(REG_CHECK_ENABLE, 32'($urandom_range(0, 7) != 0));
      cfg_write(REG_COMPARE_MODE, 32'($urandom_range(0, 15)));
      case ($urandom_range(0, 5))
        3:       cfg_write(REG_SOURCE_MASK, 32'h0000);
        4, 5:    cfg_write(REG_SOURCE_MASK, 32'($urandom_range(0, 16'hFFFF)));
        default: cfg_write(REG_SOURCE_MASK, 32'hFFFF);
      endcase
      cfg_write(REG_TRIP_THRESH, {16'd0, pick_level()});
      if ($urandom_range(0, 1))
        cfg_write(REG_CLEAR_THRESH, {16'd0, cfg_trip - 16'($urandom_range(0, 64))});
      else
        cfg_write(REG_CLEAR_THRESH, {16'd0, pick_level()});
      cfg_write(REG_TRIP_LIMIT, {16'd0, pick_limit()});
      cfg_write(REG_RELEASE_LIMIT, {16'd0, pick_limit()});
      cfg_write(REG_FAULT_CLASS, 32'($urandom_range(0, 31)));
      for (int k = 0; k < 45; k++) begin
        case ($urandom_range(0, 4))
          0:       smp = near(cfg_trip);
          1:       smp = near(cfg_reset);
          2:       smp = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
          default: smp = 16'($urandom);
        endcase
        case ($urandom_range(0, 2))
          0:       refval = near(smp);
          1:       refval = smp - near(cfg_trip);
          default: refval = 16'($urandom);
        endcase
        push_word(smp, refval);
      end
      wait_idle();
    end

    repeat (10) @(posedge clk);
    if (mismatches == 0 && status_q.size() == 0) begin
      $display("tb_filtered_threshold_fault_monitor OK");
    end else begin
      $display("tb_filtered_threshold_fault_monitor NOT OK");
    end
    $finish;
  end

endmodule
